### design/utf8_name_validator_macros.svh
// ----------------------------------------------------------------------------
// utf8_name_validator assertion macros
// concurrent assertion helpers shared by the validator rtl
// ----------------------------------------------------------------------------
`ifndef UTF8_NAME_VALIDATOR_MACROS_SVH
`define UTF8_NAME_VALIDATOR_MACROS_SVH

`ifndef ASSERT_OFF

// condition holds in the same cycle
`define UNV_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// condition holds in the next cycle
`define UNV_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define UNV_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define UNV_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

### design/unv_pkg.sv
// ----------------------------------------------------------------------------
// unv_pkg
// types and constants for the utf-8 name validator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package unv_pkg;

    localparam logic [7:0] CTRL_LIMIT  = 8'h20;
    localparam logic [7:0] DEL_CHAR    = 8'h7F;
    localparam logic [7:0] CONT_LO     = 8'h80;
    localparam logic [7:0] CONT_HI     = 8'hBF;
    localparam logic [7:0] E0_CONT_LO  = 8'hA0;
    localparam logic [7:0] ED_CONT_HI  = 8'h9F;
    localparam logic [7:0] F0_CONT_LO  = 8'h90;
    localparam logic [7:0] F4_CONT_HI  = 8'h8F;
    localparam logic [7:0] LEAD_E0     = 8'hE0;
    localparam logic [7:0] LEAD_ED     = 8'hED;
    localparam logic [7:0] LEAD_F0     = 8'hF0;
    localparam logic [7:0] LEAD_F4     = 8'hF4;

    typedef enum logic [2:0] {
        CLASS_FREE = 3'd0,
        CLASS_E0   = 3'd1,
        CLASS_ED   = 3'd2,
        CLASS_F0   = 3'd3,
        CLASS_F4   = 3'd4
    } lead_class_t;

    typedef struct packed {
        logic [1:0]  bytes_owed;
        logic        first_pending;
        lead_class_t lead_class;
        logic        error_seen;
    } unv_state_t;

    typedef struct packed {
        logic       vld;
        logic [7:0] data_byte;
        logic       final_byte;
    } unv_beat_t;

endpackage

`default_nettype wire

### design/unv_in_stage.sv
// ----------------------------------------------------------------------------
// unv_in_stage
// input register for incoming byte beats
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module unv_in_stage
    import unv_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_data_byte,
    input  wire logic       s_final_byte,
    input  wire logic       advance,
    output unv_beat_t       beat
);

    logic       vld_reg, vld_next;
    logic [7:0] byte_reg;
    logic       final_reg;

    assign s_ready = !vld_reg || advance;

    always_comb begin
        vld_next = vld_reg;
        if (s_ready) begin
            vld_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg  <= s_data_byte;
            final_reg <= s_final_byte;
        end
    end

    assign beat.vld        = vld_reg;
    assign beat.data_byte  = byte_reg;
    assign beat.final_byte = final_reg;

endmodule

`default_nettype wire

### design/unv_step.sv
// ----------------------------------------------------------------------------
// unv_step
// decodes one byte against the current sequence state
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module unv_step
    import unv_pkg::*;
(
    input  unv_state_t       cur,
    input  wire logic [7:0]  data_byte,
    output unv_state_t       nxt
);

    logic [7:0] lo;
    logic [7:0] hi;

    always_comb begin
        lo = CONT_LO;
        hi = CONT_HI;
        if (cur.first_pending) begin
            unique case (cur.lead_class)
                CLASS_E0: lo = E0_CONT_LO;
                CLASS_ED: hi = ED_CONT_HI;
                CLASS_F0: lo = F0_CONT_LO;
                CLASS_F4: hi = F4_CONT_HI;
                default:  ;
            endcase
        end
    end

    always_comb begin
        nxt = cur;
        if (!cur.error_seen) begin
            if (cur.bytes_owed != 2'd0) begin
                if (data_byte < lo || data_byte > hi) begin
                    nxt.error_seen    = 1'b1;
                    nxt.bytes_owed    = 2'd0;
                    nxt.first_pending = 1'b0;
                    nxt.lead_class    = CLASS_FREE;
                end else begin
                    nxt.first_pending = 1'b0;
                    nxt.lead_class    = CLASS_FREE;
                    nxt.bytes_owed    = cur.bytes_owed - 2'd1;
                end
            end else begin
                unique case (data_byte) inside
                    [8'h00:8'h1F], DEL_CHAR: begin
                        nxt.error_seen = 1'b1;
                    end
                    [CTRL_LIMIT:8'h7E]: ;
                    [8'hC2:8'hDF]: begin
                        nxt.bytes_owed    = 2'd1;
                        nxt.lead_class    = CLASS_FREE;
                        nxt.first_pending = 1'b1;
                    end
                    [LEAD_E0:8'hEF]: begin
                        nxt.bytes_owed    = 2'd2;
                        nxt.first_pending = 1'b1;
                        if (data_byte == LEAD_E0) begin
                            nxt.lead_class = CLASS_E0;
                        end else if (data_byte == LEAD_ED) begin
                            nxt.lead_class = CLASS_ED;
                        end else begin
                            nxt.lead_class = CLASS_FREE;
                        end
                    end
                    [LEAD_F0:LEAD_F4]: begin
                        nxt.bytes_owed    = 2'd3;
                        nxt.first_pending = 1'b1;
                        if (data_byte == LEAD_F0) begin
                            nxt.lead_class = CLASS_F0;
                        end else if (data_byte == LEAD_F4) begin
                            nxt.lead_class = CLASS_F4;
                        end else begin
                            nxt.lead_class = CLASS_FREE;
                        end
                    end
                    default: begin
                        nxt.error_seen = 1'b1;
                        nxt.lead_class = CLASS_FREE;
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

### design/utf8_name_validator.sv
// verdict path: a final beat passes the input register, then the result register
// throughput: one byte beat per cycle while no final beat waits, set by the
// combinational state update between the input register and the result register
// a waiting verdict stalls only a following final beat
// reset: synchronous active-low aresetn clears sequence state and both valids
// ----------------------------------------------------------------------------
// utf8_name_validator
// checks a byte stream for well-formed utf-8 without control characters and
// returns one verdict beat per text
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "utf8_name_validator_macros.svh"

module utf8_name_validator
    import unv_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_data_byte,
    input  wire logic       s_final_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_text_valid
);

    unv_beat_t  beat;
    logic       advance;
    unv_state_t state_reg, state_next, step_out;
    logic       m_valid_reg, m_valid_next;
    logic       verdict_reg, verdict_next;

    // a final beat needs a free result slot
    assign advance = beat.vld && (!beat.final_byte || !m_valid_reg || m_ready);

    unv_in_stage u_in (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_final_byte (s_final_byte),
        .advance      (advance),
        .beat         (beat)
    );

    unv_step u_step (
        .cur       (state_reg),
        .data_byte (beat.data_byte),
        .nxt       (step_out)
    );

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        verdict_next = verdict_reg;
        if (advance) begin
            if (beat.final_byte) begin
                state_next   = '0;
                m_valid_next = 1'b1;
                verdict_next = !step_out.error_seen && (step_out.bytes_owed == 2'd0);
            end else begin
                state_next = step_out;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        verdict_reg <= verdict_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_text_valid = verdict_reg;

    `UNV_ASSERT_NEXT(a_clear_after_verdict, aclk, aresetn, advance && beat.final_byte, state_reg == '0 && m_valid)
    `UNV_ASSERT_IMPL(a_error_owes_nothing, aclk, aresetn, state_reg.error_seen, state_reg.bytes_owed == 2'd0)
    `UNV_ASSERT_IMPL(a_pending_owes_bytes, aclk, aresetn, state_reg.first_pending, state_reg.bytes_owed != 2'd0)
    `UNV_ASSERT_IMPL(a_class_needs_pending, aclk, aresetn, state_reg.lead_class != CLASS_FREE, state_reg.first_pending)

endmodule

`default_nettype wire
